// ===== src/msis_pkg.sv =====
// Shared types and constants for the MIPS subset instruction step block.
// Depends on nothing; every other file in src imports it.
package msis_pkg;

  localparam int unsigned NUM_REGISTERS = 32;
  localparam int unsigned REG_IDX_W = 5;

  localparam logic [31:0] HALT_WORD = 32'h1000_07C0;

  // Primary opcodes.
  localparam logic [5:0] OP_SPECIAL = 6'd0;
  localparam logic [5:0] OP_BAL     = 6'd1;
  localparam logic [5:0] OP_JAL     = 6'd3;
  localparam logic [5:0] OP_BEQ     = 6'd4;
  localparam logic [5:0] OP_BNE     = 6'd5;
  localparam logic [5:0] OP_ADD_IMM = 6'd9;
  localparam logic [5:0] OP_ANDI    = 6'd12;

  // Function codes under the SPECIAL opcode.
  localparam logic [5:0] FN_JR   = 6'd8;
  localparam logic [5:0] FN_ADDU = 6'd33;
  localparam logic [5:0] FN_SUBU = 6'd35;
  localparam logic [5:0] FN_XOR  = 6'd38;
  localparam logic [5:0] FN_SLT  = 6'd42;

  localparam logic [REG_IDX_W-1:0] LINK_REG = 5'd31;

  typedef struct packed {
    logic [31:0] instruction;
    logic [31:0] current_pc;
  } step_word_t;

  typedef struct packed {
    logic [31:0]          next_pc;
    logic                 halt;
    logic                 write_enable;
    logic [REG_IDX_W-1:0] write_index;
    logic [31:0]          write_value;
  } result_word_t;

  typedef struct packed {
    logic                 we;
    logic [REG_IDX_W-1:0] idx;
    logic [31:0]          val;
  } reg_write_t;

endpackage

// ===== src/msis_regfile.sv =====
// Register file: 32 x 32 memory with two registered read ports and one write port.
// Valid bits make every entry read as zero after reset. Depends on msis_pkg.
module msis_regfile import msis_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rd_en,
  input  logic [REG_IDX_W-1:0] rd_addr_s,
  input  logic [REG_IDX_W-1:0] rd_addr_t,
  input  reg_write_t           wr,
  output logic [31:0]          rd_data_s,
  output logic [31:0]          rd_data_t
);

  logic [31:0]              mem [NUM_REGISTERS];
  logic [NUM_REGISTERS-1:0] entry_vld;

  logic [31:0]          mem_q_s;
  logic [31:0]          mem_q_t;
  logic                 vld_q_s;
  logic                 vld_q_t;
  logic [REG_IDX_W-1:0] addr_q_s;
  logic [REG_IDX_W-1:0] addr_q_t;
  reg_write_t           byp;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.idx] <= wr.val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_vld <= '0;
    end else if (wr.we) begin
      entry_vld[wr.idx] <= 1'b1;
    end
  end

  // The write made at the read edge is not in the memory output yet, so it is
  // captured alongside the read and forwarded.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q_s  <= mem[rd_addr_s];
      mem_q_t  <= mem[rd_addr_t];
      vld_q_s  <= entry_vld[rd_addr_s];
      vld_q_t  <= entry_vld[rd_addr_t];
      addr_q_s <= rd_addr_s;
      addr_q_t <= rd_addr_t;
      byp      <= wr;
    end
  end

  always_comb begin
    if (byp.we && (byp.idx == addr_q_s)) begin
      rd_data_s = byp.val;
    end else begin
      rd_data_s = vld_q_s ? mem_q_s : 32'd0;
    end
    if (byp.we && (byp.idx == addr_q_t)) begin
      rd_data_t = byp.val;
    end else begin
      rd_data_t = vld_q_t ? mem_q_t : 32'd0;
    end
  end

endmodule

// ===== src/msis_execute.sv =====
// Decode and execute logic: computes next pc, the register write and the halt flag.
// Purely combinational. Depends on msis_pkg.
module msis_execute import msis_pkg::*; (
  input  logic [31:0]  instruction,
  input  logic [31:0]  current_pc,
  input  logic [31:0]  vs,
  input  logic [31:0]  vt,
  output result_word_t res
);

  logic [5:0]           op;
  logic [5:0]           fn;
  logic [REG_IDX_W-1:0] rt;
  logic [REG_IDX_W-1:0] rd;
  logic [31:0]          zimm;
  logic [31:0]          simm;
  logic [31:0]          boff;
  logic [31:0]          pc4;
  logic [31:0]          pc8;
  logic                 we;
  logic [REG_IDX_W-1:0] widx;
  logic [31:0]          wval;
  logic [31:0]          npc;

  assign op   = instruction[31:26];
  assign fn   = instruction[5:0];
  assign rt   = instruction[20:16];
  assign rd   = instruction[15:11];
  assign zimm = {16'd0, instruction[15:0]};
  assign simm = {{16{instruction[15]}}, instruction[15:0]};
  assign boff = {simm[29:0], 2'b00};
  assign pc4  = current_pc + 32'd4;
  assign pc8  = current_pc + 32'd8;

  always_comb begin
    we   = 1'b0;
    widx = '0;
    wval = 32'd0;
    npc  = pc4;
    unique case (op)
      OP_ADD_IMM: begin
        we = 1'b1; widx = rt; wval = vs + simm;
      end
      OP_ANDI: begin
        we = 1'b1; widx = rt; wval = vs & zimm;
      end
      OP_JAL: begin
        we = 1'b1; widx = LINK_REG; wval = pc8;
        npc = {6'd0, instruction[25:0]};
      end
      OP_BAL: begin
        we = 1'b1; widx = LINK_REG; wval = pc8;
        if (!vt[31]) begin
          npc = pc4 + boff;
        end
      end
      OP_SPECIAL: begin
        unique case (fn)
          FN_ADDU: begin
            we = 1'b1; widx = rd; wval = vs + vt;
          end
          FN_XOR: begin
            we = 1'b1; widx = rd; wval = vs ^ vt;
          end
          FN_SLT: begin
            we = 1'b1; widx = rd;
            wval = {31'd0, ($signed(vs) < $signed(vt))};
          end
          FN_SUBU: begin
            we = 1'b1; widx = rd; wval = vs - vt;
          end
          FN_JR: begin
            npc = vs;
          end
          default: begin
          end
        endcase
      end
      OP_BEQ: begin
        if (vs == vt) begin
          npc = current_pc + boff;
        end
      end
      OP_BNE: begin
        if (vs != vt) begin
          npc = current_pc + boff;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res.next_pc      = npc;
    res.halt         = (instruction == HALT_WORD);
    res.write_enable = we;
    res.write_index  = widx;
    res.write_value  = wval;
  end

endmodule

// ===== src/mips_subset_instruction_step.sv =====
// An accepted word is held in the execute stage and then registered in the result register.
// Throughput: one word per cycle while result_stall is low; the operand read for the next word overlaps execution.
// Reset (rst, synchronous, active high) empties both stages and makes all 32 registers
// read as zero at once through per-entry valid bits; no clearing pass is needed.
// Depends on msis_pkg, msis_regfile and msis_execute.
module mips_subset_instruction_step import msis_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         step_valid,
  output logic         step_stall,
  input  step_word_t   step,
  output logic         result_valid,
  input  logic         result_stall,
  output result_word_t result
);

  // Execute stage: holds the accepted word while the register file delivers
  // its operands, which are read at the same edge the word is captured.
  logic       ex_valid;
  step_word_t ex_word;

  logic         ex_advance;
  logic         step_take;
  logic [31:0]  vs;
  logic [31:0]  vt;
  result_word_t ex_res;
  reg_write_t   rf_wr;

  // The execute stage moves on whenever the result register is empty or is
  // being drained in this cycle. Only a stalled result with a word already
  // waiting in the execute stage blocks a new word.
  assign ex_advance = !result_valid || !result_stall;
  assign step_stall = ex_valid && !ex_advance;
  assign step_take  = step_valid && !step_stall;

  // A register is written only when its instruction leaves the execute stage,
  // so a stalled instruction never writes twice.
  assign rf_wr.we  = ex_valid && ex_advance && ex_res.write_enable;
  assign rf_wr.idx = ex_res.write_index;
  assign rf_wr.val = ex_res.write_value;

  msis_regfile u_regfile (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (step_take),
    .rd_addr_s (step.instruction[25:21]),
    .rd_addr_t (step.instruction[20:16]),
    .wr        (rf_wr),
    .rd_data_s (vs),
    .rd_data_t (vt)
  );

  msis_execute u_execute (
    .instruction (ex_word.instruction),
    .current_pc  (ex_word.current_pc),
    .vs          (vs),
    .vt          (vt),
    .res         (ex_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      ex_valid <= 1'b0;
    end else if (ex_advance || !ex_valid) begin
      ex_valid <= step_take;
    end
  end

  always_ff @(posedge clk) begin
    if (step_take) begin
      ex_word <= step;
    end
  end

  // Result register: the write fields read as zero when nothing is written,
  // which the execute logic already guarantees.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ex_advance) begin
      result_valid <= ex_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ex_advance && ex_valid) begin
      result <= ex_res;
    end
  end

endmodule

// ===== src/msis_checker.sv =====
// Port-level checks for the MIPS subset instruction step block, bound to its top level.
// Depends on msis_pkg.
module msis_checker import msis_pkg::*; (
  input logic         clk,
  input logic         rst,
  input logic         step_valid,
  input logic         step_stall,
  input step_word_t   step,
  input logic         result_valid,
  input logic         result_stall,
  input result_word_t result
);

  // A stalled input word holds until it is taken.
  a_step_hold: assert property (@(posedge clk) disable iff (rst)
    step_valid && step_stall |=> step_valid && $stable(step))
    else $error("input word changed while stalled");

  // A stalled result word holds.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result))
    else $error("result word changed while stalled");

  // With the output side free, the block never stalls its input.
  a_no_needless_stall: assert property (@(posedge clk) disable iff (rst)
    !result_valid || !result_stall |-> !step_stall)
    else $error("input stalled while output side was free");

  // Reset leaves both stages empty.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid && !step_stall)
    else $error("pipeline not empty after reset");

  // The termination word executes as a branch and never writes a register.
  a_halt_no_write: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.halt |-> !result.write_enable
      && result.write_index == '0 && result.write_value == '0)
    else $error("termination word wrote a register");

endmodule

bind mips_subset_instruction_step msis_checker u_msis_checker (
  .clk          (clk),
  .rst          (rst),
  .step_valid   (step_valid),
  .step_stall   (step_stall),
  .step         (step),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
